### sv/gpiq_pkg.sv
// shared constants, register codes and helpers for the gamepad input qualifier
`default_nettype none

package gpiq_pkg;

    // counter layout
    localparam int BUTTON_COUNT    = 16;
    localparam int TILT_COUNT      = 8;
    localparam int COUNTER_COUNT   = BUTTON_COUNT + TILT_COUNT;
    localparam int CTR_IDX_W       = $clog2(COUNTER_COUNT);
    localparam int DIGITAL_COUNT   = 14;
    localparam int COUNT_WIDTH_DEF = 16;

    // bit positions of the digital buttons in the raw button word
    localparam logic [3:0] BUTTON_POS [DIGITAL_COUNT] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
        4'd7, 4'd8, 4'd9, 4'd12, 4'd13, 4'd14, 4'd15
    };

    // poll status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_DEVICE = 2'd1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_REPEAT_INTERVAL   = 3'd0,
        CFG_REPEAT_DELAY      = 3'd1,
        CFG_TRIGGER_THRESHOLD = 3'd2,
        CFG_LEFT_DEAD_ZONE    = 3'd3,
        CFG_RIGHT_DEAD_ZONE   = 3'd4
    } cfg_index_t;

    // register reset values
    localparam logic [7:0]  RST_REPEAT_INTERVAL   = 8'd6;
    localparam logic [7:0]  RST_REPEAT_DELAY      = 8'd20;
    localparam logic [7:0]  RST_TRIGGER_THRESHOLD = 8'd30;
    localparam logic [14:0] RST_LEFT_DEAD_ZONE    = 15'd7849;
    localparam logic [14:0] RST_RIGHT_DEAD_ZONE   = 15'd8689;

    // magnitude of a signed axis, full range fits in 16 unsigned bits
    function automatic logic [15:0] axis_mag(input logic signed [15:0] v);
        axis_mag = v[15] ? (~v + 16'd1) : v;
    endfunction

    // axis strictly positive
    function automatic logic axis_pos(input logic signed [15:0] v);
        axis_pos = !v[15] && (v != 16'sd0);
    endfunction

endpackage

`default_nettype wire

### sv/gamepad_input_qualifier.sv
// gamepad input qualifier: held counters, edge and repeat masks, radial dead zone
// sequence: dead zone squares on the shared multiplier, then per counter a read and an update,
// plus a bit-serial remainder over COUNT_WIDTH bits when past the repeat delay with a nonzero
// interval, then the output register
// flow: a new word is taken only once the last one has been loaded into the output register
// reset: asynchronous active low, counter valid bits, previous held mask, filtered axes and registers to their defaults
`default_nettype none

module gamepad_input_qualifier
    import gpiq_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input word
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          poll_status,
    input  wire logic [15:0]         button_word,
    input  wire logic [7:0]          left_trigger,
    input  wire logic [7:0]          right_trigger,
    input  wire logic signed [15:0]  left_x,
    input  wire logic signed [15:0]  left_y,
    input  wire logic signed [15:0]  right_x,
    input  wire logic signed [15:0]  right_y,
    input  wire logic [4:0]          query_index,
    // result word
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     connected,
    output logic [23:0]              held_mask,
    output logic [23:0]              pressed_mask,
    output logic [23:0]              released_mask,
    output logic [23:0]              repeat_mask,
    output logic signed [15:0]       left_x_out,
    output logic signed [15:0]       left_y_out,
    output logic signed [15:0]       right_x_out,
    output logic signed [15:0]       right_y_out,
    output logic [15:0]              queried_count,
    // configuration writes
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [14:0]         cfg_data
);

    localparam int BW = $clog2(COUNT_WIDTH);
    localparam logic [CTR_IDX_W-1:0] LAST_CTR = CTR_IDX_W'(COUNTER_COUNT - 1);
    localparam logic [2:0] LAST_STEP = 3'd7;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_RD   = 6'b000100,
        S_UPD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [7:0]  interval_reg, delay_reg, thr_reg;
    logic [14:0] ldz_reg, rdz_reg;

    // captured poll
    logic [1:0]         status_reg;
    logic [15:0]        word_reg;
    logic [7:0]         lt_reg, rt_reg;
    logic signed [15:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic [4:0]         q_reg;

    // sequencer and shared units
    logic [2:0]             step_reg;
    logic [CTR_IDX_W-1:0]   k_reg;
    logic [BW-1:0]          bit_reg;
    logic [7:0]             rem_reg;
    logic [COUNT_WIDTH-1:0] d_reg;
    logic [31:0]            prod_reg;
    logic [32:0]            acc_reg;
    logic                   lzero_reg, rzero_reg;
    logic [23:0]            active_reg;

    // stored state
    logic signed [15:0]     lxf_reg, lyf_reg, rxf_reg, ryf_reg;
    logic [COUNT_WIDTH-1:0] cnt_mem [COUNTER_COUNT];
    logic [23:0]            cnt_vld_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vld_reg;
    logic [23:0]            prev_held_reg;
    logic                   present_reg;

    // working masks
    logic [23:0] held_w_reg, pressed_w_reg, rep_w_reg, prevh_w_reg;
    logic [15:0] qc_reg;

    logic out_valid_reg;

    logic                   in_accept, upd, load_out, mem_we, last_ctr;
    logic [15:0]            mul_op;
    logic [31:0]            mul_prod;
    logic signed [15:0]     lxf, lyf, rxf, ryf;
    logic [23:0]            active_next;
    logic [COUNT_WIDTH-1:0] old_cnt, sat_inc, new_cnt, d_val;
    logic                   past_delay;
    logic [COUNT_WIDTH+15:0] qc_ext;
    logic [15:0]            qc_sat;
    logic [8:0]             shifted;
    logic                   ge;
    logic [7:0]             rem_new;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign upd       = (status_reg == STATUS_OK);
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign mem_we    = (state_reg == S_UPD) && upd;
    assign last_ctr  = (k_reg == LAST_CTR);

    // shared squaring multiplier operand
    always_comb
    begin
        case (step_reg)
            3'd0:    mul_op = axis_mag(lx_reg);
            3'd1:    mul_op = axis_mag(ly_reg);
            3'd2:    mul_op = {1'b0, ldz_reg};
            3'd3:    mul_op = axis_mag(rx_reg);
            3'd4:    mul_op = axis_mag(ry_reg);
            3'd5:    mul_op = {1'b0, rdz_reg};
            default: mul_op = 16'd0;
        endcase
    end

    assign mul_prod = {16'd0, mul_op} * {16'd0, mul_op};

    // axes after the dead zone and the active inputs of all counters
    assign lxf = lzero_reg ? 16'sd0 : lx_reg;
    assign lyf = lzero_reg ? 16'sd0 : ly_reg;
    assign rxf = rzero_reg ? 16'sd0 : rx_reg;
    assign ryf = rzero_reg ? 16'sd0 : ry_reg;

    always_comb
    begin
        active_next = '0;
        for (int i = 0; i < DIGITAL_COUNT; i++)
        begin
            active_next[i] = word_reg[BUTTON_POS[i]];
        end
        active_next[14] = (lt_reg > thr_reg);
        active_next[15] = (rt_reg > thr_reg);
        active_next[16] = axis_pos(lyf);
        active_next[17] = lyf[15];
        active_next[18] = lxf[15];
        active_next[19] = axis_pos(lxf);
        active_next[20] = axis_pos(ryf);
        active_next[21] = ryf[15];
        active_next[22] = rxf[15];
        active_next[23] = axis_pos(rxf);
    end

    // counter update for the current index
    assign old_cnt    = rd_vld_reg ? rd_data_reg : '0;
    assign sat_inc    = (old_cnt == '1) ? old_cnt : old_cnt + 1'b1;
    assign new_cnt    = upd ? (active_reg[k_reg] ? sat_inc : '0) : old_cnt;
    assign past_delay = ({8'd0, new_cnt} > {{COUNT_WIDTH{1'b0}}, delay_reg});
    assign d_val      = new_cnt - COUNT_WIDTH'(delay_reg);
    assign qc_ext     = {16'd0, new_cnt};
    assign qc_sat     = (qc_ext > (COUNT_WIDTH + 16)'(16'hFFFF)) ? 16'hFFFF : qc_ext[15:0];

    // one remainder step, one bit of the dividend per cycle
    assign shifted = {rem_reg, d_reg[bit_reg]};
    assign ge      = (shifted >= {1'b0, interval_reg});
    assign rem_new = ge ? 8'(shifted - {1'b0, interval_reg}) : shifted[7:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (step_reg == LAST_STEP)
                    state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (past_delay && (interval_reg != 8'd0))
                    state_next = S_DIV;
                else
                    state_next = last_ctr ? S_DONE : S_RD;
            end
            S_DIV:
            begin
                if (bit_reg == '0)
                    state_next = last_ctr ? S_DONE : S_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, configuration and stored state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            interval_reg  <= RST_REPEAT_INTERVAL;
            delay_reg     <= RST_REPEAT_DELAY;
            thr_reg       <= RST_TRIGGER_THRESHOLD;
            ldz_reg       <= RST_LEFT_DEAD_ZONE;
            rdz_reg       <= RST_RIGHT_DEAD_ZONE;
            present_reg   <= 1'b0;
            prev_held_reg <= '0;
            cnt_vld_reg   <= '0;
            lxf_reg       <= '0;
            lyf_reg       <= '0;
            rxf_reg       <= '0;
            ryf_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration word
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_REPEAT_INTERVAL:   interval_reg <= cfg_data[7:0];
                    CFG_REPEAT_DELAY:      delay_reg    <= cfg_data[7:0];
                    CFG_TRIGGER_THRESHOLD: thr_reg      <= cfg_data[7:0];
                    CFG_LEFT_DEAD_ZONE:    ldz_reg      <= cfg_data;
                    CFG_RIGHT_DEAD_ZONE:   rdz_reg      <= cfg_data;
                    default:               ;
                endcase
            end

            // device presence follows the poll status
            if (in_accept)
            begin
                if (poll_status == STATUS_NO_DEVICE)
                    present_reg <= 1'b0;
                else if (poll_status == STATUS_OK)
                    present_reg <= 1'b1;
            end

            // filtered axes once both dead zone flags are known
            if ((state_reg == S_MUL) && (step_reg == LAST_STEP) && upd)
            begin
                lxf_reg <= lxf;
                lyf_reg <= lyf;
                rxf_reg <= rxf;
                ryf_reg <= ryf;
            end

            if (mem_we)
                cnt_vld_reg[k_reg] <= 1'b1;

            if (load_out && upd)
                prev_held_reg <= prevh_w_reg;

            // result word handshake
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // counter memory, one port, registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= cnt_mem[k_reg];
        rd_vld_reg  <= cnt_vld_reg[k_reg];
        if (mem_we)
            cnt_mem[k_reg] <= new_cnt;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // capture the poll
        if (in_accept)
        begin
            status_reg    <= poll_status;
            word_reg      <= button_word;
            lt_reg        <= left_trigger;
            rt_reg        <= right_trigger;
            lx_reg        <= left_x;
            ly_reg        <= left_y;
            rx_reg        <= right_x;
            ry_reg        <= right_y;
            q_reg         <= query_index;
            step_reg      <= 3'd0;
            held_w_reg    <= '0;
            pressed_w_reg <= '0;
            rep_w_reg     <= '0;
            prevh_w_reg   <= '0;
            qc_reg        <= '0;
        end

        // dead zone: squares through the shared multiplier, sums and compares behind it
        if (state_reg == S_MUL)
        begin
            prod_reg <= mul_prod;
            step_reg <= step_reg + 3'd1;
            case (step_reg)
                3'd1: acc_reg   <= {1'b0, prod_reg};
                3'd2: acc_reg   <= acc_reg + {1'b0, prod_reg};
                3'd3: lzero_reg <= (acc_reg < {1'b0, prod_reg});
                3'd4: acc_reg   <= {1'b0, prod_reg};
                3'd5: acc_reg   <= acc_reg + {1'b0, prod_reg};
                3'd6: rzero_reg <= (acc_reg < {1'b0, prod_reg});
                default: ;
            endcase
            if (step_reg == LAST_STEP)
            begin
                active_reg <= active_next;
                k_reg      <= '0;
            end
        end

        // counter update and mask bits
        if (state_reg == S_UPD)
        begin
            prevh_w_reg[k_reg]   <= (old_cnt != '0);
            held_w_reg[k_reg]    <= (new_cnt != '0);
            pressed_w_reg[k_reg] <= (new_cnt == COUNT_WIDTH'(1));
            rep_w_reg[k_reg]     <= past_delay && (interval_reg == 8'd0);
            if ({{(CTR_IDX_W > 5 ? 0 : 5 - CTR_IDX_W){1'b0}}, k_reg} == q_reg)
                qc_reg <= qc_sat;
            d_reg   <= d_val;
            rem_reg <= 8'd0;
            bit_reg <= BW'(COUNT_WIDTH - 1);
            if (!(past_delay && (interval_reg != 8'd0)) && !last_ctr)
                k_reg <= k_reg + 1'b1;
        end

        // bit-serial remainder for the repeat test
        if (state_reg == S_DIV)
        begin
            rem_reg <= rem_new;
            bit_reg <= bit_reg - 1'b1;
            if (bit_reg == '0)
            begin
                rep_w_reg[k_reg] <= (rem_new == 8'd1);
                if (!last_ctr)
                    k_reg <= k_reg + 1'b1;
            end
        end

        // result word
        if (load_out)
        begin
            connected     <= present_reg;
            held_mask     <= held_w_reg;
            pressed_mask  <= pressed_w_reg;
            released_mask <= (upd ? prevh_w_reg : prev_held_reg) & ~held_w_reg;
            repeat_mask   <= rep_w_reg;
            left_x_out    <= lxf_reg;
            left_y_out    <= lyf_reg;
            right_x_out   <= rxf_reg;
            right_y_out   <= ryf_reg;
            queried_count <= qc_reg;
        end
    end

endmodule

`default_nettype wire

### test/tb_top.sv
// self-checking testbench for the gamepad input qualifier with its own poll predictor
`timescale 1ns / 100ps

module tb_top;
    import gpiq_pkg::*;

    localparam int CNT_W = COUNT_WIDTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 500;

    // status codes that leave the counters alone
    localparam logic [1:0] STATUS_READ_FAIL = 2'd2;
    localparam logic [1:0] STATUS_SPARE     = 2'd3;

    // bits of the button word that feed the digital counters, lowest first
    localparam logic [15:0] KEY_MASK = 16'hF3FF;

    // one controller poll as offered to the block
    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        buttons;
        logic [7:0]         lt;
        logic [7:0]         rt;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [4:0]         query;
        logic               hold_off;
    } poll_t;

    // one qualified result word
    typedef struct packed {
        logic               connected;
        logic [23:0]        held;
        logic [23:0]        pressed;
        logic [23:0]        released;
        logic [23:0]        rpt;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [15:0]        qcount;
    } poll_result_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // block ports
    logic               in_valid = 1'b0;
    logic               in_stall;
    poll_t              in_poll = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               connected;
    logic [23:0]        held_mask;
    logic [23:0]        pressed_mask;
    logic [23:0]        released_mask;
    logic [23:0]        repeat_mask;
    logic signed [15:0] left_x_out;
    logic signed [15:0] left_y_out;
    logic signed [15:0] right_x_out;
    logic signed [15:0] right_y_out;
    logic [15:0]        queried_count;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index = CFG_REPEAT_INTERVAL;
    logic [14:0]        cfg_data = '0;

    gamepad_input_qualifier #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .poll_status(in_poll.status),
        .button_word(in_poll.buttons),
        .left_trigger(in_poll.lt),
        .right_trigger(in_poll.rt),
        .left_x(in_poll.lx),
        .left_y(in_poll.ly),
        .right_x(in_poll.rx),
        .right_y(in_poll.ry),
        .query_index(in_poll.query),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .connected(connected),
        .held_mask(held_mask),
        .pressed_mask(pressed_mask),
        .released_mask(released_mask),
        .repeat_mask(repeat_mask),
        .left_x_out(left_x_out),
        .left_y_out(left_y_out),
        .right_x_out(right_x_out),
        .right_y_out(right_y_out),
        .queried_count(queried_count),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor copy of the registers
    logic [7:0]  rpt_interval = RST_REPEAT_INTERVAL;
    logic [7:0]  rpt_delay    = RST_REPEAT_DELAY;
    logic [7:0]  trig_thresh  = RST_TRIGGER_THRESHOLD;
    logic [14:0] dz_left      = RST_LEFT_DEAD_ZONE;
    logic [14:0] dz_right     = RST_RIGHT_DEAD_ZONE;

    // predictor copy of the held counters and stick state
    logic [CNT_W-1:0]   tally [COUNTER_COUNT] = '{default: '0};
    logic [23:0]        prev_held = '0;
    logic               present = 1'b0;
    logic signed [15:0] axes [4] = '{default: '0};

    // polls waiting for the driver and qualified words waiting for the block
    poll_t        polls_waiting [$];
    poll_result_t qualified_due [$];

    // handshake flags seen at the last rising edge
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic cfg_taken = 1'b0;

    int          mismatches = 0;
    int unsigned cycles = 0;
    int          in_gap = 0;
    int          out_hold = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;

    // one frame of a held counter, saturating
    function automatic void count_frame(input int k, input bit active);
        if (!active)
            tally[k] = '0;
        else if (tally[k] != '1)
            tally[k] = tally[k] + 1'b1;
    endfunction

    function automatic logic [23:0] held_bits();
        logic [23:0] m;
        int k;
        m = '0;
        for (k = 0; k < COUNTER_COUNT; k++)
            m[k] = (tally[k] != '0);
        return m;
    endfunction

    // radial dead zone, then the four tilt directions of one stick
    function automatic void filter_stick(input logic signed [15:0] x, y,
                                         input logic [14:0] dz, input int slot, base);
        longint mag, lim;
        mag = longint'(x) * longint'(x) + longint'(y) * longint'(y);
        lim = longint'(dz) * longint'(dz);
        if (mag < lim)
        begin
            x = '0;
            y = '0;
        end
        axes[slot] = x;
        axes[slot + 1] = y;
        count_frame(base, y > 0);
        count_frame(base + 1, y < 0);
        count_frame(base + 2, x < 0);
        count_frame(base + 3, x > 0);
    endfunction

    // advance the predictor by one poll and return the word it should produce
    function automatic poll_result_t qualify_poll(input poll_t p);
        poll_result_t r;
        int k, b, c, d;
        if (p.status == STATUS_NO_DEVICE)
            present = 1'b0;
        else if (p.status == STATUS_OK)
        begin
            present = 1'b1;
            prev_held = held_bits();
            k = 0;
            for (b = 0; b < 16; b++)
            begin
                if (KEY_MASK[b])
                begin
                    count_frame(k, p.buttons[b]);
                    k++;
                end
            end
            count_frame(14, p.lt > trig_thresh);
            count_frame(15, p.rt > trig_thresh);
            filter_stick(p.lx, p.ly, dz_left, 0, BUTTON_COUNT);
            filter_stick(p.rx, p.ry, dz_right, 2, BUTTON_COUNT + 4);
        end
        r = '0;
        r.connected = present;
        r.held = held_bits();
        r.released = prev_held & ~r.held;
        for (k = 0; k < COUNTER_COUNT; k++)
        begin
            c = int'(tally[k]);
            if (c == 1)
                r.pressed[k] = 1'b1;
            if (c > int'(rpt_delay))
            begin
                d = c - int'(rpt_delay);
                if (rpt_interval == '0 || d % int'(rpt_interval) == 1)
                    r.rpt[k] = 1'b1;
            end
        end
        r.lx = axes[0];
        r.ly = axes[1];
        r.rx = axes[2];
        r.ry = axes[3];
        if (p.query < COUNTER_COUNT)
            r.qcount = 16'(tally[p.query]);
        return r;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            mismatches++;
        end
    endfunction

    function automatic poll_t make_poll(input logic [1:0] status, input logic [15:0] buttons,
                                        input logic [7:0] lt, rt,
                                        input logic signed [15:0] lx, ly, rx, ry,
                                        input logic [4:0] query);
        poll_t p;
        p.status = status;
        p.buttons = buttons;
        p.lt = lt;
        p.rt = rt;
        p.lx = lx;
        p.ly = ly;
        p.rx = rx;
        p.ry = ry;
        p.query = query;
        p.hold_off = 1'b0;
        return p;
    endfunction

    // axis value: centred, inside the dead zone, outside it, at an end or anywhere
    function automatic logic signed [15:0] pick_axis(input logic [14:0] dz);
        int v, mode;
        mode = $urandom_range(0, 5);
        case (mode)
            0: v = 0;
            1: v = int'($urandom_range(0, dz / 2));
            2: v = int'(dz) + int'($urandom_range(0, 32767 - dz));
            3: v = 32767;
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        if (mode == 4)
            v = -32768;
        return v[15:0];
    endfunction

    // trigger value, mostly close to the threshold
    function automatic logic [7:0] pick_trigger();
        int v;
        if ($urandom_range(0, 2) == 0)
            v = $urandom_range(0, 255);
        else
            v = int'(trig_thresh) + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        else if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // runs of polls with a held button set and sticks that drift now and then
    task automatic queue_polls(input int count);
        poll_t p;
        logic [15:0] keys;
        logic [7:0] lt, rt;
        logic signed [15:0] lx, ly, rx, ry;
        logic [1:0] status;
        int run, i, r;
        while (count > 0)
        begin
            keys = 16'($urandom);
            if ($urandom_range(0, 1))
                keys = keys & 16'($urandom);
            lt = pick_trigger();
            rt = pick_trigger();
            lx = pick_axis(dz_left);
            ly = pick_axis(dz_left);
            rx = pick_axis(dz_right);
            ry = pick_axis(dz_right);
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (i = 0; i < run && count > 0; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    lx = pick_axis(dz_left);
                    ly = pick_axis(dz_left);
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    rx = pick_axis(dz_right);
                    ry = pick_axis(dz_right);
                end
                if ($urandom_range(0, 5) == 0)
                    lt = pick_trigger();
                if ($urandom_range(0, 5) == 0)
                    rt = pick_trigger();
                r = $urandom_range(0, 19);
                case (r)
                    0: status = STATUS_NO_DEVICE;
                    1: status = STATUS_READ_FAIL;
                    2: status = STATUS_SPARE;
                    default: status = STATUS_OK;
                endcase
                p = make_poll(status,
                              ($urandom_range(0, 5) == 0) ?
                                  keys ^ (16'd1 << $urandom_range(0, 15)) : keys,
                              lt, rt, lx, ly, rx, ry,
                              ($urandom_range(0, 9) == 0) ?
                                  5'($urandom_range(24, 31)) : 5'($urandom_range(0, 23)));
                p.hold_off = ($urandom_range(0, 149) == 0);
                polls_waiting.push_back(p);
                count--;
            end
        end
    endtask

    task automatic wait_idle();
        while (polls_waiting.size() != 0 || in_valid || qualified_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [14:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // new register setting once the block has gone quiet, then random polls
    task automatic run_phase(input logic [7:0] interval, delay, thresh,
                             input logic [14:0] dzl, dzr, input int count);
        wait_idle();
        write_reg(CFG_REPEAT_INTERVAL, {7'd0, interval});
        write_reg(CFG_REPEAT_DELAY, {7'd0, delay});
        write_reg(CFG_TRIGGER_THRESHOLD, {7'd0, thresh});
        write_reg(CFG_LEFT_DEAD_ZONE, dzl);
        write_reg(CFG_RIGHT_DEAD_ZONE, dzr);
        queue_polls(count);
    endtask

    // sender: present queued polls with random gaps between words
    always @(negedge clk)
    begin : feed_side
        logic show;
        show = in_valid && !in_taken;
        if (in_valid && in_taken)
        begin
            if ($urandom_range(0, 39) == 0)
                in_calm = !in_calm;
            in_gap = in_calm ? 0 : $urandom_range(0, 12);
        end
        if (!show && rst_n)
        begin
            if (in_gap > 0)
                in_gap--;
            else if (polls_waiting.size() != 0 &&
                     !(polls_waiting[0].hold_off && qualified_due.size() != 0))
            begin
                in_poll <= polls_waiting.pop_front();
                show = 1'b1;
            end
        end
        in_valid <= show;
    end

    // receiver: stall each result word for a random number of cycles
    always @(negedge clk)
    begin : drain_side
        if (out_taken)
        begin
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            out_hold = out_calm ? 0 : $urandom_range(0, 12);
        end
        else if (out_valid && out_hold > 0)
            out_hold--;
        out_stall <= (out_hold > 0);
    end

    // handshakes at the rising edge: predict, check, track register writes
    always @(posedge clk)
    begin : watch_side
        poll_result_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            out_taken <= out_valid && !out_stall;
            cfg_taken <= cfg_valid && cfg_ready;
            if (out_valid && !out_stall)
            begin
                if (qualified_due.size() == 0)
                begin
                    $error("result word arrived with none outstanding");
                    mismatches++;
                end
                else
                begin
                    want = qualified_due.pop_front();
                    compare_field("connected", {31'd0, want.connected}, {31'd0, connected});
                    compare_field("held_mask", {8'd0, want.held}, {8'd0, held_mask});
                    compare_field("pressed_mask", {8'd0, want.pressed}, {8'd0, pressed_mask});
                    compare_field("released_mask", {8'd0, want.released},
                                  {8'd0, released_mask});
                    compare_field("repeat_mask", {8'd0, want.rpt}, {8'd0, repeat_mask});
                    compare_field("left_x_out", {16'd0, want.lx}, {16'd0, left_x_out});
                    compare_field("left_y_out", {16'd0, want.ly}, {16'd0, left_y_out});
                    compare_field("right_x_out", {16'd0, want.rx}, {16'd0, right_x_out});
                    compare_field("right_y_out", {16'd0, want.ry}, {16'd0, right_y_out});
                    compare_field("queried_count", {16'd0, want.qcount},
                                  {16'd0, queried_count});
                end
            end
            if (in_valid && !in_stall)
                qualified_due.push_back(qualify_poll(in_poll));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_REPEAT_INTERVAL:   rpt_interval = cfg_data[7:0];
                    CFG_REPEAT_DELAY:      rpt_delay = cfg_data[7:0];
                    CFG_TRIGGER_THRESHOLD: trig_thresh = cfg_data[7:0];
                    CFG_LEFT_DEAD_ZONE:    dz_left = cfg_data;
                    CFG_RIGHT_DEAD_ZONE:   dz_right = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gamepad_input_qualifier test failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        poll_t p;
        int i;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed polls at the reset register values
        polls_waiting.push_back(make_poll(STATUS_OK, 16'h0000, 8'd0, 8'd0, 0, 0, 0, 0, 5'd0));
        polls_waiting.push_back(make_poll(STATUS_OK, 16'hFFFF, 8'd255, 8'd255,
                                          32767, 32767, -32768, -32768, 5'd14));
        polls_waiting.push_back(make_poll(STATUS_OK, 16'hFFFF, 8'd255, 8'd255,
                                          32767, 32767, -32768, -32768, 5'd16));
        // device gone, then read failures and the spare code: state must hold
        polls_waiting.push_back(make_poll(STATUS_NO_DEVICE, 16'h0000, 8'd0, 8'd0,
                                          0, 0, 0, 0, 5'd16));
        polls_waiting.push_back(make_poll(STATUS_READ_FAIL, 16'h1234, 8'd200, 8'd0,
                                          100, -100, 0, 0, 5'd23));
        polls_waiting.push_back(make_poll(STATUS_SPARE, 16'h8421, 8'd0, 8'd200,
                                          0, 0, -9000, 9000, 5'd0));
        // unused button bits, triggers right at and just over the threshold
        polls_waiting.push_back(make_poll(STATUS_OK, 16'h0C00, 8'd30, 8'd31,
                                          -32768, 0, 0, 32767, 5'd15));
        // dead zone edges: on the radius passes, one below is zeroed
        p = make_poll(STATUS_OK, 16'h5555, 8'd31, 8'd30, 7849, 0, 0, 8688, 5'd31);
        p.hold_off = 1'b1;
        polls_waiting.push_back(p);
        polls_waiting.push_back(make_poll(STATUS_OK, 16'hAAAA, 8'd0, 8'd255,
                                          7848, 0, 0, -8689, 5'd24));
        // diagonal just outside the radius on both sticks
        polls_waiting.push_back(make_poll(STATUS_OK, 16'hF3FF, 8'd29, 8'd0,
                                          -5550, -5551, 6144, 6145, 5'd19));
        polls_waiting.push_back(make_poll(STATUS_OK, 16'h0000, 8'd0, 8'd0,
                                          -1, 1, 1, -1, 5'd20));
        polls_waiting.push_back(make_poll(STATUS_OK, 16'h0001, 8'd0, 8'd0,
                                          0, -32768, -32768, 0, 5'd17));
        polls_waiting.push_back(make_poll(STATUS_NO_DEVICE, 16'hFFFF, 8'd255, 8'd255,
                                          0, 0, 0, 0, 5'd0));
        polls_waiting.push_back(make_poll(STATUS_OK, 16'h0001, 8'd0, 8'd0,
                                          0, 0, 0, 0, 5'd0));
        queue_polls(100);

        // lowest settings: repeat every frame, no threshold, no dead zone
        run_phase(8'd0, 8'd0, 8'd0, 15'd0, 15'd0, 200);
        // interval of one never repeats, widest dead zone, highest threshold
        run_phase(8'd1, 8'd3, 8'd255, 15'd32767, 15'd32767, 200);
        // longest delay and interval, with a hold long enough to pass them
        run_phase(8'd255, 8'd255, 8'd254, 15'($urandom), 15'($urandom), 50);
        for (i = 0; i < 300; i++)
            polls_waiting.push_back(make_poll(STATUS_OK, 16'hFFFF, 8'd255, 8'd255,
                                              -32768, 32767, 32767, -32768, 5'(i % 24)));
        // typical random settings
        run_phase(8'($urandom_range(2, 9)), 8'($urandom_range(0, 12)), 8'($urandom),
                  15'($urandom_range(3000, 16000)), 15'($urandom_range(3000, 16000)), 300);
        // back to the reset values, written explicitly
        run_phase(RST_REPEAT_INTERVAL, RST_REPEAT_DELAY, RST_TRIGGER_THRESHOLD,
                  RST_LEFT_DEAD_ZONE, RST_RIGHT_DEAD_ZONE, 150);

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("gamepad_input_qualifier test passed");
        else
            $display("gamepad_input_qualifier test failed");
        $finish;
    end

endmodule
